// ----- rtl/ba_pkg.sv -----
// shared constants, payload types and table functions of the buddy allocator
package ba_pkg;

    localparam int POOL_BYTES      = 1024;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int NUM_GRANULES    = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int NUM_LEVELS      = 7;
    localparam int TOP_LEVEL       = NUM_LEVELS - 1;
    localparam int STACK_DEPTH     = 128;
    localparam int STACK_AW        = 7;
    localparam int GRAN_AW         = 6;
    localparam int OFF_W           = 10;
    localparam int LVL_W           = 3;
    localparam int CNT_W           = 7;
    localparam int IDX_W           = 6;
    localparam int SIZE_W          = 11;
    localparam int TOTAL_W         = 17;
    localparam int HDR_W           = 4;
    localparam int GRAN_LSB        = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [9:0]  free_address;
    } ba_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  user_offset;
        logic [10:0] block_bytes;
    } ba_out_t;

    typedef struct packed {
        logic               set;
        logic               clr;
        logic               rd;
        logic [GRAN_AW-1:0] idx;
        logic [LVL_W-1:0]   lv;
    } ba_gran_op_t;

    // first stack entry of each level
    function automatic logic [STACK_AW-1:0] level_base(input logic [LVL_W-1:0] lv);
        logic [STACK_AW-1:0] b;
        case (lv)
            3'd0: b = 7'd0;
            3'd1: b = 7'd64;
            3'd2: b = 7'd96;
            3'd3: b = 7'd112;
            3'd4: b = 7'd120;
            3'd5: b = 7'd124;
            3'd6: b = 7'd126;
            default: b = 7'd127;
        endcase
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] level_cap(input logic [LVL_W-1:0] lv);
        return CNT_W'(NUM_GRANULES) >> lv;
    endfunction

    function automatic logic [SIZE_W-1:0] block_size(input logic [LVL_W-1:0] lv);
        return SIZE_W'(MIN_BLOCK_BYTES) << lv;
    endfunction

endpackage

// ----- rtl/ba_ram.sv -----
// simple dual-port ram with registered read data
module ba_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/ba_granule.sv -----
// per-granule allocated flags and level store of allocated blocks
module ba_granule import ba_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  ba_gran_op_t      op,
    output logic             alloc_bit,
    output logic [LVL_W-1:0] lv_rdata
);
    logic [NUM_GRANULES-1:0] alloc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= '0;
        end else if (op.set) begin
            alloc_reg[op.idx] <= 1'b1;
        end else if (op.clr) begin
            alloc_reg[op.idx] <= 1'b0;
        end
    end

    assign alloc_bit = alloc_reg[op.idx];

    ba_ram #(
        .DEPTH(NUM_GRANULES),
        .WIDTH(LVL_W)
    ) u_lv_ram (
        .aclk (aclk),
        .we   (op.set),
        .waddr(op.idx),
        .wdata(op.lv),
        .re   (op.rd),
        .raddr(op.idx),
        .rdata(lv_rdata)
    );
endmodule

// ----- rtl/ba_level.sv -----
// size to level: smallest level whose block holds the request plus header
module ba_level import ba_pkg::*; (
    input  logic [TOTAL_W-1:0] total,
    output logic [LVL_W-1:0]   level
);
    always_comb begin
        level = LVL_W'(TOP_LEVEL);
        for (int l = TOP_LEVEL - 1; l >= 0; l--) begin
            if ((TOTAL_W'(MIN_BLOCK_BYTES) << l) >= total) begin
                level = LVL_W'(l);
            end
        end
    end
endmodule

// ----- rtl/buddy_allocator.sv -----
// Buddy allocator over a 1024-byte pool with 16-byte minimum blocks and seven
// levels. One transaction is handled at a time by a small sequencer around a
// single-port-read free-stack ram; s_ready is high only while idle. An
// allocate steps through ALLOC, POP, one SPLIT per level split and AFIN; a
// request that does not fit goes from ALLOC to DONE, the state that hands over
// every result. A free steps through FCHK, FLV and MERGE, plus, for each level
// whose free stack is searched, one SCAN per entry read, one SHIFT per entry
// shifted down above a found buddy and one more MERGE per merge, then PUSH, so
// its worst case grows with the number of free blocks; a rejected free goes
// from FCHK to DONE. The result register lets the next transaction start while
// a result waits; header_bytes is written through the cfg channel, always ready.
module buddy_allocator import ba_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ba_in_t           s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ba_out_t          m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [HDR_W-1:0] cfg_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ALLOC = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_SPLIT = 4'd3;
    localparam logic [3:0] S_AFIN  = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_FLV   = 4'd6;
    localparam logic [3:0] S_MERGE = 4'd7;
    localparam logic [3:0] S_SCAN  = 4'd8;
    localparam logic [3:0] S_SHIFT = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]         state_reg, state_next;
    logic [HDR_W-1:0]   hdr_reg;
    ba_in_t             in_reg, in_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [LVL_W-1:0]   lv_reg, lv_next;
    logic [LVL_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    ba_out_t            res_reg, res_next;
    ba_out_t            out_reg;
    logic               m_valid_reg;
    logic [CNT_W-1:0]   cnt_reg [NUM_LEVELS];

    logic [LVL_W-1:0]    sel;
    logic [CNT_W-1:0]    cnt_sel;
    logic                cnt_inc, cnt_dec;
    logic [STACK_AW-1:0] base_sel;
    logic                st_we, st_re;
    logic [STACK_AW-1:0] st_waddr, st_raddr;
    logic [OFF_W-1:0]    st_wdata, st_rdata;
    ba_gran_op_t         gop;
    logic                alloc_bit;
    logic [LVL_W-1:0]    glev;
    logic [TOTAL_W-1:0]  total;
    logic [LVL_W-1:0]    tgt;
    logic                fnd_any;
    logic [LVL_W-1:0]    fnd_lv;
    logic [OFF_W-1:0]    off_calc;
    logic [OFF_W-1:0]    half;
    logic [OFF_W-1:0]    buddy;
    logic                out_load;

    ba_ram #(
        .DEPTH(STACK_DEPTH),
        .WIDTH(OFF_W)
    ) u_stack (
        .aclk (aclk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .re   (st_re),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    ba_granule u_gran (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (gop),
        .alloc_bit(alloc_bit),
        .lv_rdata (glev)
    );

    assign total = TOTAL_W'(in_reg.request_bytes) + TOTAL_W'(hdr_reg);

    ba_level u_level (
        .total(total),
        .level(tgt)
    );

    // lowest non-empty level at or above the target
    always_comb begin
        fnd_any = 1'b0;
        fnd_lv  = '0;
        for (int l = TOP_LEVEL; l >= 0; l--) begin
            if (LVL_W'(l) >= tgt && cnt_reg[l] != '0) begin
                fnd_any = 1'b1;
                fnd_lv  = LVL_W'(l);
            end
        end
    end

    always_comb begin
        case (state_reg)
            S_ALLOC: sel = fnd_lv;
            S_SPLIT: sel = cur_reg;
            default: sel = lv_reg;
        endcase
    end

    assign cnt_sel  = cnt_reg[sel];
    assign base_sel = level_base(sel);
    assign off_calc = in_reg.free_address - OFF_W'(hdr_reg);
    assign half     = OFF_W'(block_size(sel));
    assign buddy    = off_reg ^ half;
    assign out_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        in_next    = in_reg;
        off_next   = off_reg;
        lv_next    = lv_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        st_we      = 1'b0;
        st_waddr   = '0;
        st_wdata   = '0;
        st_re      = 1'b0;
        st_raddr   = '0;
        gop        = '0;
        gop.idx    = off_reg[OFF_W-1:GRAN_LSB];
        gop.lv     = lv_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = s_data.mode ? S_FCHK : S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (total > TOTAL_W'(POOL_BYTES) || !fnd_any) begin
                    res_next   = '{status: ST_NO_SPACE, user_offset: '0, block_bytes: '0};
                    state_next = S_DONE;
                end else begin
                    lv_next    = tgt;
                    cur_next   = fnd_lv;
                    st_re      = 1'b1;
                    st_raddr   = base_sel + STACK_AW'(cnt_sel - 1'b1);
                    cnt_dec    = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP: begin
                // the only block the top level can hold is the whole pool at zero
                off_next = (cur_reg == LVL_W'(TOP_LEVEL)) ? '0 : st_rdata;
                if (cur_reg == lv_reg) begin
                    state_next = S_AFIN;
                end else begin
                    cur_next   = cur_reg - 1'b1;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: begin
                // push the upper half; the lower half goes straight on down
                if (cnt_sel < level_cap(sel)) begin
                    st_we    = 1'b1;
                    st_waddr = base_sel + STACK_AW'(cnt_sel);
                    st_wdata = off_reg + half;
                    cnt_inc  = 1'b1;
                end
                if (cur_reg == lv_reg) begin
                    state_next = S_AFIN;
                end else begin
                    cur_next = cur_reg - 1'b1;
                end
            end
            S_AFIN: begin
                gop.set    = 1'b1;
                res_next   = '{status: ST_OK,
                               user_offset: off_reg + OFF_W'(hdr_reg),
                               block_bytes: block_size(lv_reg)};
                state_next = S_DONE;
            end
            S_FCHK: begin
                gop.idx = off_calc[OFF_W-1:GRAN_LSB];
                if (in_reg.free_address < OFF_W'(hdr_reg) ||
                    off_calc[GRAN_LSB-1:0] != '0 || !alloc_bit) begin
                    res_next   = '{status: ST_BAD_FREE, user_offset: '0, block_bytes: '0};
                    state_next = S_DONE;
                end else begin
                    gop.clr    = 1'b1;
                    gop.rd     = 1'b1;
                    off_next   = off_calc;
                    state_next = S_FLV;
                end
            end
            S_FLV: begin
                lv_next    = (glev > LVL_W'(TOP_LEVEL)) ? LVL_W'(TOP_LEVEL) : glev;
                state_next = S_MERGE;
            end
            S_MERGE: begin
                if (lv_reg == LVL_W'(TOP_LEVEL) || cnt_sel == '0) begin
                    state_next = S_PUSH;
                end else begin
                    idx_next   = IDX_W'(cnt_sel - 1'b1);
                    st_re      = 1'b1;
                    st_raddr   = base_sel + STACK_AW'(cnt_sel - 1'b1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (st_rdata == buddy) begin
                    if (CNT_W'(idx_reg) + 1'b1 < cnt_sel) begin
                        st_re      = 1'b1;
                        st_raddr   = base_sel + STACK_AW'(idx_reg) + 1'b1;
                        state_next = S_SHIFT;
                    end else begin
                        cnt_dec    = 1'b1;
                        off_next   = off_reg & ~half;
                        lv_next    = lv_reg + 1'b1;
                        state_next = S_MERGE;
                    end
                end else if (idx_reg == '0) begin
                    state_next = S_PUSH;
                end else begin
                    idx_next = idx_reg - 1'b1;
                    st_re    = 1'b1;
                    st_raddr = base_sel + STACK_AW'(idx_reg) - 1'b1;
                end
            end
            S_SHIFT: begin
                // close the gap left by the taken buddy
                st_we    = 1'b1;
                st_waddr = base_sel + STACK_AW'(idx_reg);
                st_wdata = st_rdata;
                if (CNT_W'(idx_reg) + 7'd2 < cnt_sel) begin
                    st_re    = 1'b1;
                    st_raddr = base_sel + STACK_AW'(idx_reg) + 7'd2;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    cnt_dec    = 1'b1;
                    off_next   = off_reg & ~half;
                    lv_next    = lv_reg + 1'b1;
                    state_next = S_MERGE;
                end
            end
            S_PUSH: begin
                if (cnt_sel < level_cap(sel)) begin
                    st_we    = 1'b1;
                    st_waddr = base_sel + STACK_AW'(cnt_sel);
                    st_wdata = off_reg;
                    cnt_inc  = 1'b1;
                end
                res_next   = '{status: ST_OK, user_offset: '0,
                               block_bytes: block_size(lv_reg)};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hdr_reg     <= HDR_W'(8);
            m_valid_reg <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                cnt_reg[l] <= (l == TOP_LEVEL) ? CNT_W'(1) : '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                hdr_reg <= cfg_data;
            end
            if (cnt_inc) begin
                cnt_reg[sel] <= cnt_sel + 1'b1;
            end else if (cnt_dec) begin
                cnt_reg[sel] <= cnt_sel - 1'b1;
            end
            if (state_reg == S_DONE && out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        off_reg <= off_next;
        lv_reg  <= lv_next;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (state_reg == S_DONE && out_load) begin
            out_reg <= res_reg;
        end
    end

    // the pool starts as one free block at zero, counted but not stored in entry 126
    // the top level never holds more than one entry, so its slot is written on
    // the first push; a pop of the top level therefore takes zero directly
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;
endmodule
